### src/lfsc_pkg.sv
// Light fade/strobe controller package: codes, beat widths, sequencer type
// and the random-level helper. Depends on nothing.
`default_nettype none
package lfsc_pkg;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 72;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [1:0] TYPE_STROBE = 2'd0;
	localparam logic [1:0] TYPE_SWITCH = 2'd1;
	localparam logic [1:0] TYPE_FLICKY = 2'd2;
	localparam logic [1:0] TYPE_RANDOM = 2'd3;

	localparam logic [2:0] MODE_ON    = 3'd0;
	localparam logic [2:0] MODE_OFF   = 3'd1;
	localparam logic [2:0] MODE_UP    = 3'd2;
	localparam logic [2:0] MODE_DOWN  = 3'd3;
	localparam logic [2:0] MODE_FLICK = 3'd4;

	localparam logic [2:0] REG_LIGHT_TYPE = 3'd0;
	localparam logic [2:0] REG_INIT_STATE = 3'd1;
	localparam logic [2:0] REG_FADE_UP    = 3'd2;
	localparam logic [2:0] REG_FADE_DOWN  = 3'd3;
	localparam logic [2:0] REG_ON_HOLD    = 3'd4;
	localparam logic [2:0] REG_OFF_HOLD   = 3'd5;
	localparam logic [2:0] REG_BASE       = 3'd6;

	localparam logic [30:0] RATE_RESET  = 31'd429496729;
	localparam logic [15:0] BASE_RESET  = 16'd65535;
	localparam logic [31:0] ONE_FX      = 32'd65536;
	localparam logic [31:0] FLICKER_PER = 32'd1750;
	localparam logic [31:0] JITTER_PER  = 32'd3553;
	localparam logic [15:0] LVL_SET     = 16'ha000;
	localparam logic [15:0] LVL_KEEP    = ~16'hf000;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_STEP  = 4'b0010,
		ST_UPD   = 4'b0100,
		ST_SCALE = 4'b1000
	} seq_state_t;

	// residue mod 3 via base-4 digit sums (4 = 1 mod 3)
	function automatic logic [1:0] mod3_16(input logic [15:0] v);
		logic [4:0] s;
		logic [2:0] t;
		logic [1:0] r;
		s = '0;
		for (int i = 0; i < 8; i++) begin
			s = s + 5'(v[2*i +: 2]);
		end
		t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
		unique case (t)
			3'd0, 3'd3, 3'd6: r = 2'd0;
			3'd1, 3'd4, 3'd7: r = 2'd1;
			default:          r = 2'd2;
		endcase
		return r;
	endfunction

	// r mod 24 < 8 exactly when r mod 3 equals (r mod 8) mod 3
	function automatic logic [31:0] rand_level(input logic [15:0] r);
		logic low;
		low = (mod3_16({13'd0, r[2:0]}) == mod3_16(r));
		return low ? {16'd0, r | LVL_SET} : {16'd0, r & LVL_KEEP};
	endfunction

endpackage
`default_nettype wire

### src/light_fade_strobe_controller.sv
// Light fade/strobe/flicker controller top level: config registers, state,
// one shared 21x32 multiplier under a four-state sequencer. Uses lfsc_pkg.
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tuser: req_type; tdata: frame_time, random_value, new_state
// m_*      out  m_tvalid/m_tready  tdata: level_multiplier, brightness, light_state
// cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// Each item runs step multiply, state update, then scale multiply into the output
// register, in turn, since the one multiplier is shared between the steps.
// s_tready is high only in idle; cfg_ready is always high.
// A result waiting in the output register stalls only the scale step.
// arst_n clears control state and loads register defaults.
`default_nettype none
module light_fade_strobe_controller (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output      logic                            s_tready,
	// [19:0] frame_time, [35:20] random_value, [38:36] new_state, [39] zero
	input  wire logic [lfsc_pkg::S_TDATA_W-1:0]  s_tdata,
	// [0] req_type
	input  wire logic                            s_tuser,
	output      logic                            m_tvalid,
	input  wire logic                            m_tready,
	// [31:0] level_multiplier, [63:32] brightness, [66:64] light_state, [71:67] zero
	output      logic [lfsc_pkg::M_TDATA_W-1:0]  m_tdata,
	input  wire logic                            cfg_valid,
	output      logic                            cfg_ready,
	input  wire logic [lfsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lfsc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lfsc_pkg::*;

	seq_state_t state_q;

	logic [1:0]  type_q;
	logic [2:0]  init_q;
	logic [30:0] up_rate_q, down_rate_q, on_rate_q, off_rate_q;
	logic [15:0] base_q;

	logic [2:0]  mode_q;
	logic [31:0] level_q, phase_q, flick_q;

	logic        req_q;
	logic [19:0] ft_q;
	logic [15:0] rnd_q;
	logic [2:0]  ns_q;
	logic [31:0] diff_q;

	logic        m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic signed [20:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [52:0] mul_p;
	logic [30:0] rate_sel;

	logic [2:0]  mode_d;
	logic [31:0] level_d, phase_d, flick_d;
	logic [31:0] ft_ext, pt_step, pt_ft, fl_ft, rnd_lvl;

	logic        cfg_fire, in_fire, out_free;
	logic [1:0]  rin_type;
	logic [2:0]  rin_init, rin_mode;
	logic [31:0] bright;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid & cfg_ready;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid & s_tready;
	assign out_free  = ~m_tvalid_q | m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	always_comb begin
		unique case (mode_q)
			MODE_UP:   rate_sel = up_rate_q;
			MODE_DOWN: rate_sel = down_rate_q;
			MODE_OFF:  rate_sel = off_rate_q;
			default:   rate_sel = on_rate_q;
		endcase
	end

	assign mul_a = (state_q == ST_SCALE) ? $signed({5'd0, base_q}) : $signed({1'b0, ft_q});
	assign mul_b = (state_q == ST_SCALE) ? $signed(level_q) : $signed({1'b0, rate_sel});
	assign mul_p = mul_a * mul_b;

	assign bright = (type_q == TYPE_RANDOM && mode_q == MODE_OFF) ? 32'd0 : mul_p[47:16];

	assign ft_ext  = {12'd0, ft_q};
	assign pt_step = phase_q + diff_q;
	assign pt_ft   = phase_q + ft_ext;
	assign fl_ft   = flick_q + ft_ext;
	assign rnd_lvl = rand_level(rnd_q);

	always_comb begin
		mode_d  = mode_q;
		level_d = level_q;
		phase_d = phase_q;
		flick_d = flick_q;
		priority if (req_q) begin
			mode_d  = ns_q;
			phase_d = '0;
			flick_d = '0;
		end else if (type_q == TYPE_RANDOM) begin
			if (mode_q == MODE_FLICK) begin
				if (pt_ft > FLICKER_PER) begin
					level_d = rnd_lvl;
					phase_d = '0;
				end else begin
					phase_d = pt_ft;
				end
			end
		end else if (mode_q == MODE_UP) begin
			if (type_q == TYPE_FLICKY) begin
				if (fl_ft > JITTER_PER) begin
					level_d = rnd_lvl;
					flick_d = '0;
				end else begin
					flick_d = fl_ft;
				end
			end else begin
				level_d = level_q + diff_q;
			end
			if (pt_step > ONE_FX) begin
				mode_d  = MODE_ON;
				phase_d = '0;
				level_d = ONE_FX;
			end else begin
				phase_d = pt_step;
			end
		end else if (mode_q == MODE_DOWN) begin
			level_d = level_q - diff_q;
			if (pt_step > ONE_FX) begin
				mode_d  = MODE_OFF;
				phase_d = '0;
				level_d = '0;
			end else begin
				phase_d = pt_step;
			end
		end else if (type_q == TYPE_STROBE &&
		             (mode_q == MODE_ON || mode_q == MODE_OFF)) begin
			if (pt_step > ONE_FX) begin
				mode_d  = (mode_q == MODE_ON) ? MODE_DOWN : MODE_UP;
				phase_d = '0;
			end else begin
				phase_d = pt_step;
			end
		end
	end

	// reload values for a type or initial-state write
	assign rin_type = (cfg_index == REG_LIGHT_TYPE) ? cfg_data[1:0] : type_q;
	assign rin_init = (cfg_index == REG_INIT_STATE) ? cfg_data[2:0] : init_q;
	assign rin_mode = (rin_type == TYPE_RANDOM) ? MODE_FLICK : rin_init;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			m_tvalid_q  <= 1'b0;
			type_q      <= TYPE_STROBE;
			init_q      <= MODE_ON;
			up_rate_q   <= RATE_RESET;
			down_rate_q <= RATE_RESET;
			on_rate_q   <= RATE_RESET;
			off_rate_q  <= RATE_RESET;
			base_q      <= BASE_RESET;
			mode_q      <= MODE_ON;
			level_q     <= ONE_FX;
			phase_q     <= '0;
			flick_q     <= '0;
		end else begin
			if (state_q == ST_SCALE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					mode_q  <= mode_d;
					level_q <= level_d;
					phase_q <= phase_d;
					flick_q <= flick_d;
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_fire) begin
				unique case (cfg_index)
					REG_LIGHT_TYPE: type_q      <= cfg_data[1:0];
					REG_INIT_STATE: init_q      <= cfg_data[2:0];
					REG_FADE_UP:    up_rate_q   <= cfg_data[30:0];
					REG_FADE_DOWN:  down_rate_q <= cfg_data[30:0];
					REG_ON_HOLD:    on_rate_q   <= cfg_data[30:0];
					REG_OFF_HOLD:   off_rate_q  <= cfg_data[30:0];
					REG_BASE:       base_q      <= cfg_data[15:0];
					default: ;
				endcase
				if (cfg_index == REG_LIGHT_TYPE || cfg_index == REG_INIT_STATE) begin
					mode_q  <= rin_mode;
					level_q <= (rin_mode == MODE_OFF) ? 32'd0 : ONE_FX;
					phase_q <= '0;
					flick_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q <= s_tuser;
			ft_q  <= s_tdata[19:0];
			rnd_q <= s_tdata[35:20];
			ns_q  <= s_tdata[38:36];
		end
		if (state_q == ST_STEP) begin
			diff_q <= mul_p[47:16];
		end
		if (state_q == ST_SCALE && out_free) begin
			m_tdata_q <= {5'd0, mode_q, bright, level_q};
		end
	end

endmodule
`default_nettype wire

### src/lfsc_checker.sv
// Port-level checks for light_fade_strobe_controller, bound to the top level.
// Uses lfsc_pkg for beat widths.
`default_nettype none
module lfsc_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_tvalid,
	input wire logic                           s_tready,
	input wire logic                           m_tvalid,
	input wire logic                           m_tready,
	input wire logic [lfsc_pkg::M_TDATA_W-1:0] m_tdata
);
	import lfsc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat dropped or changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
		else $error("input ready too soon after an accepted beat");

	a_stall_keeps_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready && !s_tready |=> !s_tready)
		else $error("input ready while a result is still blocked");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without an item in flight");

endmodule

bind light_fade_strobe_controller lfsc_checker u_lfsc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
